[rtl/dds_sine_generator_with_amplitude_unit_assert.svh]
// Assertion macros used by the checker file of the sine generator.
// No dependencies; include by bare file name.
`ifndef DDS_SINE_GENERATOR_WITH_AMPLITUDE_UNIT_ASSERT_SVH
`define DDS_SINE_GENERATOR_WITH_AMPLITUDE_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define DSG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define DSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `DSG_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

[rtl/dsg_pkg.sv]
// Package for the DDS sine generator: payload types, register codes,
// reset values and the quarter-wave-free 64-entry sine table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsg_pkg;

   localparam int PHASE_W    = 16;
   localparam int AMP_W      = 4;
   localparam int DUTY_W     = 8;
   localparam int ROM_ADDR_W = 6;
   localparam int ROM_DEPTH  = 1 << ROM_ADDR_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 16'd10;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 4'd15;

   localparam logic [DUTY_W-1:0] SINE_ROM [ROM_DEPTH] = '{
      8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
      8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
      8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
      8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
      8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
      8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1,
      8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
      8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115
   };

   typedef struct packed {
      logic enable;
   } req_payload_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              generating;
   } rsp_payload_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_step;
      logic [AMP_W-1:0]   amplitude;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/dsg_stream_if.sv]
// Valid/ready stream interface carrying one payload struct per request.
// Payload type is a parameter; used with the types of dsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dsg_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
   modport monitor(input valid, input ready, input data);
endinterface

`default_nettype wire

[rtl/dsg_csr.sv]
// Configuration registers (phase step and amplitude) of the sine generator.
// Depends on dsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsg_csr
   import dsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PHASE_STEP: cfg_in.phase_step = csr_wdata[PHASE_W-1:0];
            CSR_AMPLITUDE:  cfg_in.amplitude  = csr_wdata[AMP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step <= PHASE_STEP_RESET;
         cfg_ff.amplitude  <= AMPLITUDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/dsg_scale.sv]
// Sine table lookup and 4-bit shift-add amplitude scaling.
// Depends on dsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsg_scale
   import dsg_pkg::*;
(
   input  wire logic [ROM_ADDR_W-1:0] addr,
   input  wire logic [AMP_W-1:0]      amplitude,
   output logic      [DUTY_W-1:0]     scaled
);

   logic [DUTY_W-1:0] entry;

   // largest sum is 236, fits without saturation
   always_comb begin
      entry  = SINE_ROM[addr];
      scaled = (amplitude[3] ? (entry >> 1) : '0)
             + (amplitude[2] ? (entry >> 2) : '0)
             + (amplitude[1] ? (entry >> 3) : '0)
             + (amplitude[0] ? (entry >> 4) : '0);
   end

endmodule

`default_nettype wire

[rtl/dsg_core.sv]
// Phase accumulator, held duty value and idle/generate mode.
// Depends on dsg_pkg and dsg_scale.
`timescale 1ns / 1ps
`default_nettype none

module dsg_core
   import dsg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              enable,
   input  cfg_type                cfg,
   output logic      [DUTY_W-1:0] duty,
   output logic                   gen_mode
);

   logic [PHASE_W-1:0] accum_ff, accum_in, accum_sum;
   logic [DUTY_W-1:0]  duty_ff, duty_in, scaled;
   logic               gen_ff, gen_in;

   assign accum_sum = accum_ff + cfg.phase_step;

   dsg_scale u_scale (
      .addr      (accum_sum[PHASE_W-1 -: ROM_ADDR_W]),
      .amplitude (cfg.amplitude),
      .scaled    (scaled)
   );

   always_comb begin
      accum_in = accum_ff;
      duty_in  = duty_ff;
      gen_in   = gen_ff;
      if (advance) begin
         gen_in = enable;
         if (gen_ff) begin
            accum_in = accum_sum;
            duty_in  = scaled;
         end else begin
            accum_in = '0;
            duty_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         duty_ff  <= '0;
         gen_ff   <= 1'b0;
      end else begin
         accum_ff <= accum_in;
         duty_ff  <= duty_in;
         gen_ff   <= gen_in;
      end
   end

   assign duty     = duty_ff;
   assign gen_mode = gen_ff;

endmodule

`default_nettype wire

[rtl/dds_sine_generator_with_amplitude_unit.sv]
// DDS sine generator with amplitude scaling, top level.
// Result registered in the cycle after accept; one request per cycle unless stalled.
// The output register is refilled in the cycle it is taken, so ready only drops
// while a result is held. Reset (synchronous) clears phase, duty and mode, sets phase
// step to 10, amplitude to 15. Depends on dsg_pkg, dsg_stream_if, dsg_csr, dsg_core.
`timescale 1ns / 1ps
`default_nettype none

module dds_sine_generator_with_amplitude_unit
   import dsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   dsg_stream_if.sink                 req,
   dsg_stream_if.source               rsp,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg;
   req_payload_type   req_data;
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic [DUTY_W-1:0] duty;
   logic              gen_mode;

   assign req_data  = req.data;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   dsg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   dsg_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .enable   (req_data.enable),
      .cfg      (cfg),
      .duty     (duty),
      .gen_mode (gen_mode)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.duty       = duty;
         rsp_data_in.generating = gen_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/dsg_checker.sv]
// Port-level checks for the sine generator top level, with its bind.
// Depends on dsg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "dds_sine_generator_with_amplitude_unit_assert.svh"

module dsg_checker
   import dsg_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input rsp_payload_type rsp_data
);

   `DSG_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid,
      "request accepted but no result next cycle")
   `DSG_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready,
      "not ready with empty output register")
   `DSG_ASSERT(a_duty_range, clock, reset, rsp_valid |-> (rsp_data.duty <= 8'd236),
      "duty above scaled maximum")
   `DSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind dds_sine_generator_with_amplitude_unit dsg_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

`default_nettype wire

[tb/sv/dds_sine_generator_with_amplitude_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking test of the DDS sine generator: drives enable ticks with random
// handshake gaps and checks every duty result against a cycle-free predictor.
// Depends on dsg_pkg, dsg_stream_if and dds_sine_generator_with_amplitude_unit.

module dds_sine_generator_with_amplitude_unit_test;
   import dsg_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dsg_stream_if #(.payload_type(req_payload_type)) req_if ();
   dsg_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   dds_sine_generator_with_amplitude_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // predictor state
   logic [PHASE_W-1:0] gen_phase;
   logic [DUTY_W-1:0]  gen_duty;
   logic               gen_active;
   logic [PHASE_W-1:0] gen_step;
   logic [AMP_W-1:0]   gen_amp;

   req_payload_type tick_backlog [$];
   rsp_payload_type duty_due [$];
   int              mismatch_count;
   bit              gaps_on;
   int              send_gap;
   int              take_stall;

   function automatic logic [DUTY_W-1:0] scaled_level(input logic [DUTY_W-1:0] level,
                                                      input logic [AMP_W-1:0] gain);
      logic [DUTY_W:0] total;
      total = '0;
      if (gain[3]) total += level >> 1;
      if (gain[2]) total += level >> 2;
      if (gain[1]) total += level >> 3;
      if (gain[0]) total += level >> 4;
      return total[DUTY_W-1:0];
   endfunction

   // result for one tick, then the tick's update
   function automatic rsp_payload_type sine_tick(input req_payload_type tick);
      rsp_payload_type result;
      result.duty       = gen_duty;
      result.generating = gen_active;
      if (!gen_active) begin
         gen_phase = '0;
         gen_duty  = '0;
         if (tick.enable) gen_active = 1'b1;
      end else begin
         gen_phase = gen_phase + gen_step;
         gen_duty  = scaled_level(SINE_ROM[gen_phase[PHASE_W-1 -: ROM_ADDR_W]], gen_amp);
         if (!tick.enable) gen_active = 1'b0;
      end
      return result;
   endfunction

   always #5 clock = ~clock;

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) duty_due.push_back(sine_tick(req_if.data));
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (tick_backlog.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 18);
               req_if.valid <= 1'b0;
            end else begin
               req_if.valid <= 1'b1;
               req_if.data  <= tick_backlog.pop_front();
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (duty_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result duty=%0d generating=%0b", $realtime,
                           rsp_if.data.duty, rsp_if.data.generating);
            end else begin
               want = duty_due.pop_front();
               if (rsp_if.data.duty !== want.duty ||
                   rsp_if.data.generating !== want.generating) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected duty=%0d generating=%0b, got duty=%0d generating=%0b",
                              $realtime, want.duty, want.generating,
                              rsp_if.data.duty, rsp_if.data.generating);
               end
            end
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_if.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            take_stall = $urandom_range(0, 18);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_if.valid || duty_due.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_PHASE_STEP: gen_step = value[PHASE_W-1:0];
         CSR_AMPLITUDE:  gen_amp  = value[AMP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_pattern(input logic [31:0] pattern, input int count);
      req_payload_type tick;
      @(negedge clock);
      for (int i = count - 1; i >= 0; i--) begin
         tick.enable = pattern[i];
         tick_backlog.push_back(tick);
      end
      wait_idle();
   endtask

   task automatic queue_random(input int count, input int off_pct);
      req_payload_type tick;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         tick.enable = ($urandom_range(0, 99) >= off_pct);
         tick_backlog.push_back(tick);
      end
      wait_idle();
   endtask

   initial begin
      logic [PHASE_W-1:0] step;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PHASE_STEP;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.data      = '0;
      rsp_if.ready     = 1'b0;
      gaps_on          = 1'b0;
      mismatch_count   = 0;
      gen_phase        = '0;
      gen_duty         = '0;
      gen_active       = 1'b0;
      gen_step         = PHASE_STEP_RESET;
      gen_amp          = AMPLITUDE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: enter, run, leave, re-enter
      queue_pattern(32'b11110010110, 11);
      // widest step, top gain bit only, junk above the amplitude field
      write_reg(CSR_PHASE_STEP, 16'hFFFF);
      write_reg(CSR_AMPLITUDE, 16'hFFF8);
      gaps_on = 1'b1;
      queue_pattern(32'b11110, 5);
      // zero step and zero gain
      write_reg(CSR_PHASE_STEP, 16'h0000);
      write_reg(CSR_AMPLITUDE, 16'h0000);
      queue_pattern(32'b1110, 4);
      write_reg(CSR_PHASE_STEP, 16'h0400);
      write_reg(CSR_AMPLITUDE, 16'h0001);
      queue_pattern(32'b1111, 4);

      for (int p = 0; p < 20; p++) begin
         case ($urandom_range(0, 3))
            0:       step = 16'($urandom_range(0, 16'hFFFF));
            1:       step = {6'($urandom_range(1, 8)), 10'd0};
            2:       step = 16'($urandom_range(0, 64));
            default: step = 16'hFFFF - 16'($urandom_range(0, 64));
         endcase
         write_reg(CSR_PHASE_STEP, step);
         write_reg(CSR_AMPLITUDE, {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))});
         gaps_on = (p < 17) && (p % 4 != 3);
         queue_random(100, (p % 5 == 4) ? 50 : 3);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && duty_due.size() == 0)
         $display("PASS dds_sine_generator_with_amplitude_unit");
      else
         $display("FAIL dds_sine_generator_with_amplitude_unit");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL dds_sine_generator_with_amplitude_unit");
      $finish;
   end

endmodule

[dds_sine_generator_with_amplitude_unit.f]
+incdir+rtl
rtl/dsg_pkg.sv
rtl/dsg_stream_if.sv
rtl/dsg_csr.sv
rtl/dsg_scale.sv
rtl/dsg_core.sv
rtl/dds_sine_generator_with_amplitude_unit.sv
rtl/dsg_checker.sv
tb/sv/dds_sine_generator_with_amplitude_unit_test.sv
